// File: rtl/core/mah_pkg.sv
`default_nettype none
package mah_pkg;
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MULTIPLIER = 1'd1;
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic rem_start;
    logic pop_step;
    logic bin_rd;
    logic bin_wr;
    logic out_load;
  } mah_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic rem_done;
    logic pop_done;
    logic is_read;
  } mah_sts_t;
endpackage
`default_nettype wire

// File: rtl/core/mah_in_if.sv
`default_nettype none
interface mah_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [63:0] state_word;
  logic [5:0]  flip_bit;
  logic [6:0]  bin_index;
  modport source (output valid, mode, state_word, flip_bit, bin_index, input ready);
  modport sink (input valid, mode, state_word, flip_bit, bin_index, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mah_out_if.sv
`default_nettype none
interface mah_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  bits_changed;
  logic [31:0] bin_count;
  logic [31:0] total_changes;
  logic [31:0] zero_count;
  logic [31:0] sample_count;
  modport source (output valid, bits_changed, bin_count, total_changes, zero_count,
                  sample_count, input ready);
  modport sink (input valid, bits_changed, bin_count, total_changes, zero_count,
                sample_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mah_ctrl.sv
`default_nettype none
module mah_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            out_busy_i,
  input  wire mah_pkg::mah_sts_t sts_i,
  output mah_pkg::mah_cmd_t    cmd_o
);
  import mah_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_REM, S_POP, S_RD, S_WR, S_OUT
  } state_e;
  state_e state_q;

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == S_IDLE);
    cmd_o.load = in_ready_o && in_valid_i;
    cmd_o.mul_start = (state_q == S_MUL);
    cmd_o.rem_start = (state_q == S_MUL) && sts_i.mul_done;
    cmd_o.pop_step = (state_q == S_POP);
    cmd_o.bin_rd = (state_q == S_RD);
    cmd_o.bin_wr = (state_q == S_WR);
    cmd_o.out_load = (state_q == S_OUT) && !out_busy_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_MUL;
        S_MUL: begin
          if (sts_i.is_read) state_q <= S_RD;
          else if (sts_i.mul_done) state_q <= S_REM;
        end
        S_REM: if (sts_i.rem_done) state_q <= S_POP;
        S_POP: if (sts_i.pop_done) state_q <= S_RD;
        S_RD: state_q <= S_WR;
        S_WR: state_q <= S_OUT;
        S_OUT: if (!out_busy_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_out_from_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(state_q) == S_WR || $past(state_q) == S_OUT)
    else $error("output without bin update");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_o.load) else $error("load while busy");
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.bin_wr |-> $past(cmd_o.bin_rd)) else $error("write without read");
endmodule
`default_nettype wire

// File: rtl/core/mah_dp.sv
`default_nettype none
module mah_dp #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mah_pkg::mah_cmd_t        cmd_i,
  output mah_pkg::mah_sts_t             sts_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [mah_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [mah_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     mode_i,
  input  wire logic [63:0]              word_i,
  input  wire logic [5:0]               flip_i,
  input  wire logic [6:0]               bin_i,
  output logic [6:0]                    dist_o,
  output logic [COUNT_BITS-1:0]         count_o,
  output logic [COUNT_BITS-1:0]         sum_o,
  output logic [COUNT_BITS-1:0]         zero_o,
  output logic [COUNT_BITS-1:0]         samp_o
);
  import mah_pkg::*;
  localparam int unsigned BINS = WORD_BITS + 1;
  localparam int unsigned BW = $clog2(BINS);
  localparam int unsigned FW = $clog2(WORD_BITS);
  localparam int unsigned CW = $clog2(WORD_BITS + 1);
  localparam int unsigned HALF = (WORD_BITS + 1) / 2;
  localparam int unsigned HI = WORD_BITS - HALF;
  localparam int unsigned PW = 2 * HALF;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [WORD_BITS-1:0] mod_q, mul_q, a_q, b_q;
  logic mode_q;
  logic [6:0] bin_q;
  logic [1:0] mph_q;
  logic [WORD_BITS-1:0] acc_a_q, acc_b_q;
  // remainder units: restoring, one quotient bit a cycle
  logic [WORD_BITS:0] ra_q, rb_q;
  logic [WORD_BITS-1:0] qa_q, qb_q;
  logic [CW-1:0] rcnt_q, pcnt_q;
  logic rbusy_q, rdone_q;
  logic [WORD_BITS-1:0] x_q;
  logic [CW-1:0] dist_q;
  logic [COUNT_BITS-1:0] bins_q [BINS];
  logic [BINS-1:0] bval_q;
  logic [COUNT_BITS-1:0] rdv_q, cnt_q, sum_q, zero_q, samp_q;

  logic [FW-1:0] fidx;
  logic [6:0] fred;
  logic [WORD_BITS-1:0] wrd;
  assign wrd = word_i[WORD_BITS-1:0];

  // flip index folded into the word by repeated compare and subtract
  always_comb begin
    fred = {1'b0, flip_i};
    for (int k = 0; k < 8; k++) begin
      if (fred >= 7'(WORD_BITS)) fred = fred - 7'(WORD_BITS);
    end
  end
  assign fidx = FW'(fred);

  // low word of the product split into three partial products over cycles
  logic [HALF-1:0] al, bl, gl;
  logic [HI-1:0] ah, bh, gh;
  assign al = a_q[HALF-1:0], ah = a_q[WORD_BITS-1:HALF];
  assign bl = b_q[HALF-1:0], bh = b_q[WORD_BITS-1:HALF];
  assign gl = mul_q[HALF-1:0], gh = mul_q[WORD_BITS-1:HALF];
  logic [HALF-1:0] ea, eb, eg;
  logic [PW-1:0] prod_a, prod_b;
  always_comb begin
    case (mph_q)
      2'd0: begin ea = al; eb = bl; eg = gl; end
      2'd1: begin ea = HALF'(ah); eb = HALF'(bh); eg = gl; end
      default: begin ea = al; eb = bl; eg = HALF'(gh); end
    endcase
  end
  assign prod_a = ea * eg;
  assign prod_b = eb * eg;
  logic [WORD_BITS-1:0] pp_a, pp_b;
  assign pp_a = (mph_q == 2'd0) ? WORD_BITS'(prod_a) : WORD_BITS'(prod_a) << HALF;
  assign pp_b = (mph_q == 2'd0) ? WORD_BITS'(prod_b) : WORD_BITS'(prod_b) << HALF;

  logic [WORD_BITS:0] sa, sb;
  assign sa = {ra_q[WORD_BITS-1:0], qa_q[WORD_BITS-1]};
  assign sb = {rb_q[WORD_BITS-1:0], qb_q[WORD_BITS-1]};
  logic [WORD_BITS:0] mx;
  assign mx = {1'b0, mod_q};
  logic [WORD_BITS-1:0] ha, hb, x_d;
  assign ha = (mod_q == '0) ? acc_a_q : ra_q[WORD_BITS-1:0];
  assign hb = (mod_q == '0) ? acc_b_q : rb_q[WORD_BITS-1:0];
  assign x_d = ha ^ hb;

  logic [BW-1:0] bidx;
  logic bin_ok;
  always_comb begin
    if (mode_q == MODE_READ) begin
      bin_ok = (bin_q < 7'(BINS));
      bidx = BW'(bin_q);
    end else begin
      bin_ok = 1'b1;
      bidx = BW'(dist_q);
    end
  end

  logic [COUNT_BITS-1:0] inc_cnt;
  assign inc_cnt = (rdv_q == CMAX) ? CMAX : rdv_q + COUNT_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_rd) begin
      rdv_q <= (bin_ok && bval_q[bidx]) ? bins_q[bidx] : '0;
    end
    if (cmd_i.bin_wr && mode_q == MODE_SAMPLE) begin
      bins_q[bidx] <= inc_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= WORD_BITS'(1);
      mul_q <= '0;
      mode_q <= MODE_SAMPLE;
      bin_q <= '0;
      a_q <= '0;
      b_q <= '0;
      acc_a_q <= '0;
      acc_b_q <= '0;
      mph_q <= '0;
      ra_q <= '0;
      rb_q <= '0;
      qa_q <= '0;
      qb_q <= '0;
      rbusy_q <= 1'b0;
      rdone_q <= 1'b0;
      pcnt_q <= '0;
      rcnt_q <= '0;
      x_q <= '0;
      dist_q <= '0;
      bval_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
      zero_q <= '0;
      samp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODULUS: mod_q <= cfg_data_i[WORD_BITS-1:0];
          REG_MULTIPLIER: mul_q <= cfg_data_i[WORD_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        mode_q <= mode_i;
        bin_q <= bin_i;
        a_q <= wrd;
        b_q <= wrd ^ (WORD_BITS'(1) << fidx);
        mph_q <= '0;
        acc_a_q <= '0;
        acc_b_q <= '0;
        rdone_q <= 1'b0;
      end
      if (cmd_i.mul_start && mph_q != 2'd3) begin
        acc_a_q <= acc_a_q + pp_a;
        acc_b_q <= acc_b_q + pp_b;
        mph_q <= mph_q + 2'd1;
      end
      if (cmd_i.rem_start) begin
        rbusy_q <= 1'b1;
        rcnt_q <= '0;
        ra_q <= '0;
        rb_q <= '0;
        qa_q <= acc_a_q;
        qb_q <= acc_b_q;
      end else if (rbusy_q) begin
        ra_q <= (sa >= mx) ? sa - mx : sa;
        rb_q <= (sb >= mx) ? sb - mx : sb;
        qa_q <= qa_q << 1;
        qb_q <= qb_q << 1;
        rcnt_q <= rcnt_q + CW'(1);
        if (rcnt_q == CW'(WORD_BITS - 1)) begin
          rbusy_q <= 1'b0;
          rdone_q <= 1'b1;
        end
      end
      if (rdone_q && !cmd_i.pop_step) begin
        x_q <= x_d;
        dist_q <= '0;
        pcnt_q <= '0;
      end
      if (cmd_i.pop_step) begin
        rdone_q <= 1'b0;
        dist_q <= dist_q + CW'(x_q[0]);
        x_q <= x_q >> 1;
        pcnt_q <= pcnt_q + CW'(1);
      end
      if (cmd_i.bin_wr) begin
        if (mode_q == MODE_SAMPLE) begin
          cnt_q <= inc_cnt;
          bval_q[bidx] <= 1'b1;
          sum_q <= ((COUNT_BITS+1)'(sum_q) + (COUNT_BITS+1)'(dist_q) > (COUNT_BITS+1)'(CMAX))
                   ? CMAX : sum_q + COUNT_BITS'(dist_q);
          if (dist_q == '0 && zero_q != CMAX) zero_q <= zero_q + COUNT_BITS'(1);
          if (samp_q != CMAX) samp_q <= samp_q + COUNT_BITS'(1);
        end else begin
          cnt_q <= rdv_q;
        end
      end
    end
  end

  assign sts_o.mul_done = (mph_q == 2'd3);
  assign sts_o.rem_done = rdone_q;
  assign sts_o.pop_done = (pcnt_q == CW'(WORD_BITS - 1)) && cmd_i.pop_step;
  assign sts_o.is_read = (mode_q == MODE_READ);
  assign dist_o = (mode_q == MODE_READ) ? 7'd0 : 7'(dist_q);
  assign count_o = cnt_q;
  assign sum_o = sum_q;
  assign zero_o = zero_q;
  assign samp_o = samp_q;

  a_samp_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(samp_q) == CMAX |-> samp_q == CMAX) else $error("sample count wrapped");
  a_sum_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q >= $past(sum_q)) else $error("total decreased");
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q <= CW'(WORD_BITS)) else $error("distance out of range");
endmodule
`default_nettype wire

// File: rtl/core/modmul_avalanche_histogram.sv
`default_nettype none
// flow: a sample goes through the partial products, the two remainder units running
// in parallel, the popcount steps, bin read, bin write and output load; a read goes
// through bin read, bin write and output load
// throughput: one item at a time, a new item is accepted only back in idle, and the
// output load waits while the output is held off
// reset: asynchronous active low, all bins read zero through valid bits,
// modulus 1, multiplier 0, counters zero
module modmul_avalanche_histogram #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [mah_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [mah_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  mah_in_if.sink    in_if,
  mah_out_if.source out_if
);
  import mah_pkg::*;
  mah_cmd_t cmd;
  mah_sts_t sts;
  logic [6:0] ham_dist;
  logic [COUNT_BITS-1:0] cnt, sum, zero, samp;
  logic ovalid_q;

  mah_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_busy_i(ovalid_q && !out_if.ready), .sts_i(sts), .cmd_o(cmd)
  );

  mah_dp #(.WORD_BITS(WORD_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mode_i(in_if.mode), .word_i(in_if.state_word), .flip_i(in_if.flip_bit),
    .bin_i(in_if.bin_index), .dist_o(ham_dist), .count_o(cnt), .sum_o(sum),
    .zero_o(zero), .samp_o(samp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        ovalid_q <= 1'b1;
        out_if.bits_changed <= ham_dist;
        out_if.bin_count <= 32'(cnt);
        out_if.total_changes <= 32'(sum);
        out_if.zero_count <= 32'(zero);
        out_if.sample_count <= 32'(samp);
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end
  assign out_if.valid = ovalid_q;
endmodule
`default_nettype wire
